/* design/serial_loaded_bank_mapper_unit_defines.svh */
// Assertion macros for the serial loaded bank mapper.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef SERIAL_LOADED_BANK_MAPPER_UNIT_DEFINES_SVH
`define SERIAL_LOADED_BANK_MAPPER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that is switched off while reset is held.
`define SLBM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slbm check failed");
// Check that holds on every clock edge, reset included.
`define SLBM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("slbm check failed");
`else
`define SLBM_ASSERT(label, clk, rst_n, prop)
`define SLBM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* design/slbm_pkg.sv */
// Shared types and constants for the serial loaded bank mapper.
// Used by serial_loaded_bank_mapper_unit; depends on nothing.
package slbm_pkg;

    // Result target codes.
    localparam logic [2:0] T_ROM    = 3'd0;
    localparam logic [2:0] T_PRGRAM = 3'd1;
    localparam logic [2:0] T_CHRRAM = 3'd2;
    localparam logic [2:0] T_VRAM   = 3'd3;
    localparam logic [2:0] T_PORT   = 3'd4;
    localparam logic [2:0] T_NONE   = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PRG_BASE    = 3'd0;
    localparam logic [2:0] CFG_CHR_BASE    = 3'd1;
    localparam logic [2:0] CFG_PRG_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_CHR_PRESENT = 3'd3;

    // Source of the read data that travels with an item.
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_PRG  = 2'd1;
    localparam logic [1:0] SRC_CHR  = 2'd2;

    // Internal RAM sizes.
    localparam int PRG_RAM_BYTES_DEF = 8192;
    localparam int CHR_RAM_BYTES_DEF = 8192;

    // Reset values.
    localparam logic [19:0] PRG_BASE_RST   = 20'd16;
    localparam logic [19:0] CHR_BASE_RST   = 20'd16400;
    localparam logic [18:0] PRG_LENGTH_RST = 19'd32768;
    localparam logic [4:0]  SR_EMPTY       = 5'h10;
    localparam logic [4:0]  CONTROL_RST    = 5'h0C;

    // Bank register selected by address bits 14:13.
    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_CHR0    = 2'd1;
    localparam logic [1:0] SEL_CHR1    = 2'd2;
    localparam logic [1:0] SEL_PRG     = 2'd3;

    typedef logic [19:0] t_addr;

endpackage

/* design/serial_loaded_bank_mapper_unit.sv */
// Serial loaded bank mapper: bus access decode, bank registers and internal RAMs.
// Depends on slbm_pkg and serial_loaded_bank_mapper_unit_defines.svh.
//
// Usage: each input item is one CPU or PPU bus access (kind, bus_address,
// write_data). Every item yields exactly one result item: the target, the
// mapped ROM byte address, RAM index or VRAM offset, and the byte read from
// the internal PRG or CHR RAM. CPU writes at $8000-$FFFF feed the serial
// shift register that loads the control and bank registers.
// An accepted item passes through stage A and then the output register before
// its result can be taken. Without i_out_stall it sustains one item per cycle;
// the RAM read port and the bank registers are updated at the accepting edge,
// so each item sees all earlier writes.
// The two result stages act as an output register plus skid stage: while
// i_out_stall is high the block keeps taking items until both stages are
// full, then raises o_in_stall.
// Configuration writes are ready whenever reset is released and should be
// issued while idle.
// Reset (synchronous, active low) holds o_in_stall high, empties the pipeline
// and restores the bank and configuration registers; RAM contents are not cleared.
`include "serial_loaded_bank_mapper_unit_defines.svh"
module serial_loaded_bank_mapper_unit
    import slbm_pkg::*;
#(
    parameter int PRG_RAM_BYTES = PRG_RAM_BYTES_DEF,
    parameter int CHR_RAM_BYTES = CHR_RAM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    // Input item channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_in_kind,
    input  logic [15:0] i_in_bus_address,
    input  logic [7:0]  i_in_write_data,
    // Result item channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_out_target,
    output logic [19:0] o_out_mapped_address,
    output logic [7:0]  o_out_read_data
);

    localparam int PRG_AW = $clog2(PRG_RAM_BYTES);
    localparam int CHR_AW = $clog2(CHR_RAM_BYTES);

    // Configuration registers.
    t_addr       r_prg_base;
    t_addr       r_chr_base;
    logic [18:0] r_prg_len;
    logic        r_chr_present;

    // Mapper state.
    logic [4:0] r_shift;
    logic [4:0] r_control;
    logic [4:0] r_chr0;
    logic [4:0] r_chr1;
    logic [4:0] r_prg;

    // Memories and their registered read data.
    logic [7:0] prg_ram [PRG_RAM_BYTES];
    logic [7:0] chr_ram [CHR_RAM_BYTES];
    logic [7:0] r_prg_q;
    logic [7:0] r_chr_q;

    // Pipeline stage after the RAM read.
    logic        r_a_valid;
    logic [2:0]  r_a_target;
    t_addr       r_a_maddr;
    logic [1:0]  r_a_src;
    logic        r_b_valid;

    // Handshake.
    logic accept;
    logic adv_a;
    logic ram_rd;
    logic both_full;

    // Decode results.
    logic [2:0]        n_target;
    t_addr             n_maddr;
    logic [1:0]        n_src;
    logic              prg_we;
    logic              chr_we;
    logic              port_we;
    t_addr             prg_off;
    t_addr             chr_off;
    t_addr             nt_off;
    logic [15:0]       nt_addr;
    logic [15:0]       prg_diff;
    logic [PRG_AW-1:0] prg_idx;
    logic [CHR_AW-1:0] chr_idx;
    logic [4:0]        n_shift;
    logic [4:0]        shifted;

    assign o_cfg_ready = i_rst_n;
    assign adv_a       = r_a_valid && (!r_b_valid || !i_out_stall);
    assign o_in_stall  = !i_rst_n || (r_a_valid && !adv_a);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_b_valid;
    assign ram_rd      = (n_src != SRC_NONE);
    assign both_full   = r_a_valid && r_b_valid;

    // PRG ROM offset from the control mode and the PRG bank.
    always_comb begin
        unique case (r_control[3:2])
            2'd0, 2'd1: begin
                prg_off = 20'(i_in_bus_address[14:0])
                        + (20'({r_prg[3:1], 1'b0}) << 14);
            end
            2'd2: begin
                if (!i_in_bus_address[14]) begin
                    prg_off = 20'(i_in_bus_address[13:0]);
                end else begin
                    prg_off = 20'(i_in_bus_address[13:0]) + (20'(r_prg[3:0]) << 14);
                end
            end
            default: begin
                if (!i_in_bus_address[14]) begin
                    prg_off = 20'(i_in_bus_address[13:0]) + (20'(r_prg[3:0]) << 14);
                end else begin
                    prg_off = 20'(i_in_bus_address[13:0]) + 20'(r_prg_len) - 20'h4000;
                end
            end
        endcase
    end

    // CHR offset: one 8K bank or two 4K banks.
    always_comb begin
        if (!r_control[4]) begin
            chr_off = 20'(i_in_bus_address[12:0]) + (20'({r_chr0[4:1], 1'b0}) << 12);
        end else if (i_in_bus_address[12]) begin
            chr_off = 20'(i_in_bus_address[11:0]) + (20'(r_chr1) << 12);
        end else begin
            chr_off = 20'(i_in_bus_address[11:0]) + (20'(r_chr0) << 12);
        end
    end

    // Nametable offset through the mirroring mode; $3000 mirrors $2000.
    always_comb begin
        nt_addr = (i_in_bus_address >= 16'h3000) ? i_in_bus_address - 16'h1000
                                                 : i_in_bus_address;
        unique case (r_control[1:0])
            2'd0:    nt_off = 20'(nt_addr[9:0]);
            2'd1:    nt_off = 20'({1'b1, nt_addr[9:0]});
            2'd2:    nt_off = 20'(nt_addr[10:0]);
            default: nt_off = 20'({(nt_addr >= 16'h2800), nt_addr[9:0]});
        endcase
    end

    assign prg_diff = i_in_bus_address - 16'h6000;
    assign prg_idx  = prg_diff[PRG_AW-1:0];
    assign chr_idx  = chr_off[CHR_AW-1:0];

    // Access decode.
    always_comb begin
        n_target = T_NONE;
        n_maddr  = '0;
        n_src    = SRC_NONE;
        prg_we   = 1'b0;
        chr_we   = 1'b0;
        port_we  = 1'b0;
        if (!i_in_kind[1]) begin
            if (i_in_bus_address >= 16'h6000 && i_in_bus_address <= 16'h7FFF) begin
                n_target = T_PRGRAM;
                n_maddr  = 20'(prg_idx);
                prg_we   = i_in_kind[0];
                n_src    = i_in_kind[0] ? SRC_NONE : SRC_PRG;
            end else if (i_in_bus_address[15]) begin
                if (i_in_kind[0]) begin
                    n_target = T_PORT;
                    n_maddr  = 20'(i_in_bus_address[14:13]);
                    port_we  = 1'b1;
                end else begin
                    n_target = T_ROM;
                    n_maddr  = r_prg_base + prg_off;
                end
            end
        end else begin
            if (i_in_bus_address <= 16'h1FFF) begin
                if (r_chr_present) begin
                    if (!i_in_kind[0]) begin
                        n_target = T_ROM;
                        n_maddr  = r_chr_base + chr_off;
                    end
                end else begin
                    n_target = T_CHRRAM;
                    n_maddr  = 20'(chr_idx);
                    chr_we   = i_in_kind[0];
                    n_src    = i_in_kind[0] ? SRC_NONE : SRC_CHR;
                end
            end else if (i_in_bus_address <= 16'h3EFF) begin
                n_target = T_VRAM;
                n_maddr  = nt_off;
            end
        end
    end

    // Serial shift register: bit 7 empties it, the fifth bit loads a register.
    assign shifted = {i_in_write_data[0], r_shift[4:1]};
    always_comb begin
        if (i_in_write_data[7] || r_shift[0]) begin
            n_shift = SR_EMPTY;
        end else begin
            n_shift = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= SR_EMPTY;
            r_control <= CONTROL_RST;
            r_chr0    <= '0;
            r_chr1    <= '0;
            r_prg     <= '0;
        end else if (accept && port_we) begin
            r_shift <= n_shift;
            if (!i_in_write_data[7] && r_shift[0]) begin
                unique case (i_in_bus_address[14:13])
                    SEL_CONTROL: r_control <= shifted;
                    SEL_CHR0:    r_chr0    <= shifted;
                    SEL_CHR1:    r_chr1    <= shifted;
                    SEL_PRG:     r_prg     <= shifted;
                    default:     r_prg     <= shifted;
                endcase
            end
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_base    <= PRG_BASE_RST;
            r_chr_base    <= CHR_BASE_RST;
            r_prg_len     <= PRG_LENGTH_RST;
            r_chr_present <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PRG_BASE:    r_prg_base    <= i_cfg_data;
                CFG_CHR_BASE:    r_chr_base    <= i_cfg_data;
                CFG_PRG_LENGTH:  r_prg_len     <= i_cfg_data[18:0];
                CFG_CHR_PRESENT: r_chr_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // PRG RAM: write or read in place at the accepting edge.
    always_ff @(posedge i_clk) begin
        if (accept && prg_we) begin
            prg_ram[prg_idx] <= i_in_write_data;
        end
        if (accept && n_src == SRC_PRG) begin
            r_prg_q <= prg_ram[prg_idx];
        end
    end

    // CHR RAM: banked address wrapped to its size.
    always_ff @(posedge i_clk) begin
        if (accept && chr_we) begin
            chr_ram[chr_idx] <= i_in_write_data;
        end
        if (accept && n_src == SRC_CHR) begin
            r_chr_q <= chr_ram[chr_idx];
        end
    end

    // Stage A control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (adv_a) begin
            r_a_valid <= 1'b0;
        end
    end

    // Stage A payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_target <= n_target;
            r_a_maddr  <= n_maddr;
            r_a_src    <= n_src;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv_a) begin
            r_b_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    // Output register payload with the read data selected.
    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            o_out_target         <= r_a_target;
            o_out_mapped_address <= r_a_maddr;
            case (r_a_src)
                SRC_PRG: o_out_read_data <= r_prg_q;
                SRC_CHR: o_out_read_data <= r_chr_q;
                default: o_out_read_data <= 8'd0;
            endcase
        end
    end

    // The shift register always holds its marker bit somewhere.
    `SLBM_ASSERT(a_shift_nonzero, i_clk, i_rst_n, r_shift != 5'd0)
    // No item is taken while reset is held.
    `SLBM_ASSERT_ALWAYS(a_stall_in_reset, i_clk, !i_rst_n |-> o_in_stall)
    // Out of reset, input is only held off when stage A is occupied.
    `SLBM_ASSERT(a_stall_needs_item, i_clk, i_rst_n, !o_in_stall || r_a_valid)
    // An accepted RAM read leaves an item in stage A that takes the RAM data.
    `SLBM_ASSERT(a_ram_read_tracked, i_clk, i_rst_n, (accept && ram_rd) |=> r_a_src != SRC_NONE)
    // A full output register with a full stage A under stall keeps both.
    `SLBM_ASSERT(a_hold_under_stall, i_clk, i_rst_n, (both_full && i_out_stall) |=> both_full)

endmodule
